// File: rtl/lca_pkg.sv
// Package of shared types, constants and helpers for the binary-lifting LCA engine.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;
	localparam int NODE_W    = 10;
	localparam int DEPTH_W   = 10;
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NODE_AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int ANC_DEPTH = MAX_NODES * LEVELS;
	localparam int ANC_AW    = $clog2(ANC_DEPTH);

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [ANC_AW-1:0]  anc_addr_t;
	typedef logic [NODE_AW-1:0] node_addr_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam depth_t DEPTH_MAX = '1;
	localparam lvl_t   LVL_TOP   = lvl_t'(LEVELS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_DEP,
		S_INS_LVL,
		S_Q_DEP,
		S_LIFT,
		S_CHK,
		S_DESC,
		S_LAST,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  valid;
		node_t ancestor;
	} res_t;

	// Flat address of one entry of the ancestor table: row per node, one word per level.
	function automatic anc_addr_t anc_addr(input node_t node, input lvl_t lvl);
		return anc_addr_t'(ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl));
	endfunction

endpackage

`default_nettype wire

// File: rtl/lca_req_if.sv
// Request channel interface: operation code and two node numbers.
`timescale 1ns / 1ps
`default_nettype none

interface lca_req_if
	import lca_pkg::*;
	();
	logic  valid;
	logic  ready;
	logic  op;
	node_t first_node;
	node_t second_node;

	modport source (output valid, output op, output first_node, output second_node,
		input ready);
	modport sink (input valid, input op, input first_node, input second_node,
		output ready);
endinterface

`default_nettype wire

// File: rtl/lca_rsp_if.sv
// Response channel interface: the lowest common ancestor of a query.
`timescale 1ns / 1ps
`default_nettype none

interface lca_rsp_if
	import lca_pkg::*;
	();
	logic  valid;
	logic  ready;
	node_t ancestor;

	modport source (output valid, output ancestor, input ready);
	modport sink (input valid, input ancestor, output ready);
endinterface

`default_nettype wire

// File: rtl/lca_ram.sv
// Generic synchronous RAM: one write port, two registered read ports, write-first.
`timescale 1ns / 1ps
`default_nettype none

module lca_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 10,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	output logic      [WIDTH-1:0]  rdata_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read of the entry being written returns the new word.
	always_ff @(posedge clk) begin
		rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
		rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
	end

endmodule

`default_nettype wire

// File: rtl/lca_engine.sv
// Sequencer that walks the ancestor and depth memories for inserts and queries.
`timescale 1ns / 1ps
`default_nettype none

module lca_engine
	import lca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lca_req_if.sink   req,
	output res_t      res,
	input  wire logic res_ready
);

	state_t state_q, state_d;

	node_t  node_q;
	node_t  other_q;
	node_t  res_q;
	depth_t diff_q;
	lvl_t   lvl_q;
	logic   pend_q;
	logic   za_q, zb_q;

	// Memory ports
	logic       anc_we;
	anc_addr_t  anc_waddr;
	node_t      anc_wdata;
	node_t      rd_node_a, rd_node_b;
	lvl_t       rd_lvl_a, rd_lvl_b;
	node_t      anc_rd_a, anc_rd_b;
	logic       dep_we;
	depth_t     dep_wdata;
	depth_t     dep_rd_a, dep_rd_b;

	node_t  ra, rb, b_lift, a_step, b_step;
	logic   differ, last_lvl, accept;
	depth_t ins_d;

	lca_ram #(.DEPTH(ANC_DEPTH), .WIDTH(NODE_W)) u_anc_ram (
		.clk     (clk),
		.we      (anc_we),
		.waddr   (anc_waddr),
		.wdata   (anc_wdata),
		.raddr_a (anc_addr(rd_node_a, rd_lvl_a)),
		.rdata_a (anc_rd_a),
		.raddr_b (anc_addr(rd_node_b, rd_lvl_b)),
		.rdata_b (anc_rd_b)
	);

	lca_ram #(.DEPTH(MAX_NODES), .WIDTH(DEPTH_W)) u_dep_ram (
		.clk     (clk),
		.we      (dep_we),
		.waddr   (node_addr_t'(node_q)),
		.wdata   (dep_wdata),
		.raddr_a (node_addr_t'(req.first_node)),
		.rdata_a (dep_rd_a),
		.raddr_b (node_addr_t'(req.second_node)),
		.rdata_b (dep_rd_b)
	);

	// Row zero is never written and stands for "no node", so it reads as zero.
	assign ra       = za_q ? '0 : anc_rd_a;
	assign rb       = zb_q ? '0 : anc_rd_b;
	assign b_lift   = pend_q ? ra : other_q;
	assign differ   = (ra != rb);
	assign a_step   = differ ? ra : node_q;
	assign b_step   = differ ? rb : other_q;
	assign last_lvl = (lvl_q == LVL_TOP);
	assign accept   = req.valid && req.ready;
	assign ins_d    = (other_q == '0) ? depth_t'(1) :
		(dep_rd_b == DEPTH_MAX) ? DEPTH_MAX : depth_t'(dep_rd_b + 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.op == OP_QUERY) begin
						state_d = ((req.first_node == '0) || (req.second_node == '0)) ?
							S_DONE : S_Q_DEP;
					end else begin
						state_d = (req.first_node == '0) ? S_IDLE : S_INS_DEP;
					end
				end
			end
			S_INS_DEP: state_d = (LEVELS > 1) ? S_INS_LVL : S_IDLE;
			S_INS_LVL: state_d = last_lvl ? S_IDLE : S_INS_LVL;
			S_Q_DEP:   state_d = S_LIFT;
			S_LIFT:    state_d = last_lvl ? S_CHK : S_LIFT;
			S_CHK:     state_d = (node_q == b_lift) ? S_DONE : S_DESC;
			S_DESC:    state_d = (lvl_q == '0) ? S_LAST : S_DESC;
			S_LAST:    state_d = S_DONE;
			S_DONE:    state_d = res_ready ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready    = 1'b0;
		anc_we       = 1'b0;
		anc_waddr    = anc_addr(node_q, lvl_q);
		anc_wdata    = ra;
		rd_node_a    = node_q;
		rd_lvl_a     = lvl_q;
		rd_node_b    = other_q;
		rd_lvl_b     = lvl_q;
		dep_we       = 1'b0;
		dep_wdata    = ins_d;
		res.valid    = (state_q == S_DONE);
		res.ancestor = res_q;
		unique case (state_q)
			S_IDLE: req.ready = 1'b1;
			S_INS_DEP: begin
				dep_we    = 1'b1;
				anc_we    = 1'b1;
				anc_waddr = anc_addr(node_q, '0);
				anc_wdata = other_q;
				rd_node_a = other_q;
				rd_lvl_a  = '0;
			end
			S_INS_LVL: begin
				anc_we    = 1'b1;
				rd_node_a = ra;
			end
			S_LIFT: rd_node_a = b_lift;
			S_CHK: begin
				rd_lvl_a  = LVL_TOP;
				rd_node_b = b_lift;
				rd_lvl_b  = LVL_TOP;
			end
			S_DESC: begin
				rd_node_a = a_step;
				rd_node_b = b_step;
				rd_lvl_a  = (lvl_q == '0) ? '0 : lvl_t'(lvl_q - 1'b1);
				rd_lvl_b  = (lvl_q == '0) ? '0 : lvl_t'(lvl_q - 1'b1);
			end
			S_Q_DEP, S_LAST, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			za_q    <= 1'b0;
			zb_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			za_q    <= (rd_node_a == '0);
			zb_q    <= (rd_node_b == '0);
			if (state_q == S_Q_DEP) begin
				pend_q <= 1'b0;
			end else if (state_q == S_LIFT) begin
				pend_q <= diff_q[lvl_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					node_q  <= req.first_node;
					other_q <= req.second_node;
					res_q   <= '0;
				end
			end
			S_INS_DEP: lvl_q <= lvl_t'(1);
			S_INS_LVL: lvl_q <= lvl_t'(lvl_q + 1'b1);
			S_Q_DEP: begin
				lvl_q <= '0;
				if (dep_rd_a > dep_rd_b) begin
					node_q  <= other_q;
					other_q <= node_q;
					diff_q  <= depth_t'(dep_rd_a - dep_rd_b);
				end else begin
					diff_q  <= depth_t'(dep_rd_b - dep_rd_a);
				end
			end
			S_LIFT: begin
				other_q <= b_lift;
				lvl_q   <= lvl_t'(lvl_q + 1'b1);
			end
			S_CHK: begin
				other_q <= b_lift;
				res_q   <= node_q;
				lvl_q   <= LVL_TOP;
			end
			S_DESC: begin
				node_q  <= a_step;
				other_q <= b_step;
				lvl_q   <= lvl_t'(lvl_q - 1'b1);
			end
			S_LAST: res_q <= ra;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/binary_lifting_lca.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
// Insert: depth and level zero are written together, then the higher levels one a cycle, before the next word is taken.
// Query: the deeper node is lifted through every level, then both nodes descend from the top level
// unless one is an ancestor of the other; a query naming node zero answers zero without a walk.
// One item at a time; the next is taken while a result waits in the output register.
// Reset clears control only; both memories stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module binary_lifting_lca
	import lca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lca_req_if.sink   req,
	lca_rsp_if.source rsp
);

	// The engine reads the depth memory for both nodes of a query together, lifts the
	// deeper node one level a cycle, then, unless the two already match, walks both nodes
	// down from the top level, using the two read ports of the ancestor memory. Every read
	// feeds the next address, so the walk proceeds at one memory access per cycle.
	res_t  res;
	logic  res_ready;
	logic  out_valid_q;
	node_t out_anc_q;

	lca_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_ready (res_ready)
	);

	// The output register frees the engine as soon as the word is copied in, so the
	// engine can take a new item while the consumer stalls.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_anc_q <= res.ancestor;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.ancestor = out_anc_q;

	// A query naming node zero answers zero on the next cycle.
	a_zero_query: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.op == OP_QUERY) &&
		((req.first_node == '0) || (req.second_node == '0)))
		|=> (res.valid && (res.ancestor == '0)))
		else $error("zero-node query did not answer zero");

	// An insert never produces a result.
	a_insert_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.op == OP_INSERT)) |=> !res.valid)
		else $error("insert produced a result");

	// A result handed over by the engine shows up unchanged at the output.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res_ready) |=> (rsp.valid && (rsp.ancestor == $past(res.ancestor))))
		else $error("result word lost on its way to the output register");

endmodule

`default_nettype wire

// File: dv/lca_checker.sv
// Checker for the LCA engine: follows both channels, predicts every answer and compares it.
`timescale 1ns / 1ps

module lca_checker
	import lca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lca_req_if        req,
	lca_rsp_if        rsp,
	output int        mismatches,
	output int        awaiting,
	output int        compared
);

	// Private copy of the lifting tables. Row 0 is never written and reads as "no node".
	node_t  anc_of   [MAX_NODES][LEVELS];
	depth_t depth_of [MAX_NODES];
	node_t  expected_anc [$];
	node_t  want;

	initial begin
		foreach (anc_of[n, l]) anc_of[n][l] = '0;
		foreach (depth_of[n]) depth_of[n] = '0;
		mismatches = 0;
		awaiting   = 0;
		compared   = 0;
	end

	function automatic void record_insert(input node_t node, input node_t parent);
		int unsigned d;
		if (node == '0 || int'(node) >= MAX_NODES || int'(parent) >= MAX_NODES)
			return;
		d = (parent == '0) ? 1 : int'(depth_of[parent]) + 1;
		if (d > DEPTH_MAX)
			d = DEPTH_MAX;
		depth_of[node]  = depth_t'(d);
		anc_of[node][0] = parent;
		for (int l = 1; l < LEVELS; l++)
			anc_of[node][l] = anc_of[anc_of[node][l-1]][l-1];
	endfunction

	function automatic node_t lowest_common(input node_t a, input node_t b);
		node_t       t;
		int unsigned gap;
		if (a == '0 || b == '0 || int'(a) >= MAX_NODES || int'(b) >= MAX_NODES)
			return '0;
		if (depth_of[a] > depth_of[b]) begin
			t = a;
			a = b;
			b = t;
		end
		gap = int'(depth_of[b]) - int'(depth_of[a]);
		for (int l = 0; l < LEVELS; l++)
			if (((gap >> l) & 1) != 0)
				b = anc_of[b][l];
		if (a == b)
			return a;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (anc_of[a][l] != anc_of[b][l]) begin
				a = anc_of[a][l];
				b = anc_of[b][l];
			end
		end
		return anc_of[a][0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				if (req.op == OP_QUERY)
					expected_anc.insert(expected_anc.size(),
						lowest_common(req.first_node, req.second_node));
				else
					record_insert(req.first_node, req.second_node);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_anc.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word: ancestor %0d with no query waiting",
							rsp.ancestor);
				end else begin
					want = expected_anc.pop_front();
					compared++;
					if (rsp.ancestor !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch on answer %0d: expected ancestor %0d, got %0d",
								compared, want, rsp.ancestor);
					end
				end
			end
			awaiting = expected_anc.size();
		end
	end

endmodule

// File: dv/binary_lifting_lca_tb.sv
// Testbench top for the binary-lifting LCA engine: stimulus, stall patterns and the verdict.
`timescale 1ns / 1ps

module binary_lifting_lca_tb;
	import lca_pkg::*;

	// Random forest-building words before the long path phase.
	localparam int FOREST_ITEMS     = 30;
	// Length of each long output stall; the engine must back up and stall its input.
	localparam int LONG_HOLD_CYCLES = 200;
	// Covers anything still in flight at the end.
	localparam int DRAIN_CYCLES     = 40;
	// Path position from which both sides stop idling.
	localparam int QUIET_FROM       = 880;

	logic clk;
	logic arst_n;

	lca_req_if req_ch ();
	lca_rsp_if rsp_ch ();

	int mismatches;
	int awaiting;
	int compared;

	// Stimulus-side view of the tree, used only to pick legal node numbers.
	// A node is queried or used as a parent only after it has been inserted, so the
	// engine never reads a table row that holds nothing.
	bit    placed      [MAX_NODES];
	node_t parent_of   [MAX_NODES];
	node_t placed_list [$];
	node_t path_order  [MAX_NODES-1];

	bit idle_en;
	bit hold_req;
	int inserts_sent;
	int queries_sent;

	binary_lifting_lca DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	lca_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.mismatches(mismatches),
		.awaiting  (awaiting),
		.compared  (compared)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Safety net: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout: the engine stopped making progress.");
		$display("CHECKS FAILED");
		$finish;
	end

	// Offers one word and returns at the falling edge after it was taken. An optional
	// idle burst comes first. Valid changes only at falling edges, and at most once in
	// any time step, so back-to-back words keep valid high without a glitch.
	task automatic send_word(input logic op, input node_t a_node, input node_t b_node);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.first_node  <= a_node;
		req_ch.second_node <= b_node;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		if (op == OP_QUERY)
			queries_sent++;
		else
			inserts_sent++;
	endtask

	// Sends an insert and keeps the local view of the tree in step with it.
	task automatic put_node(input node_t node, input node_t parent);
		send_word(OP_INSERT, node, parent);
		if (node != '0) begin
			if (!placed[node])
				placed_list.insert(placed_list.size(), node);
			placed[node]    = 1'b1;
			parent_of[node] = parent;
		end
	endtask

	function automatic node_t any_placed();
		return placed_list[$urandom_range(0, placed_list.size() - 1)];
	endfunction

	// Favoring the latest nodes as parents lets the trees grow deep instead of bushy.
	function automatic node_t recent_placed();
		int lo;
		lo = (placed_list.size() > 8) ? placed_list.size() - 8 : 0;
		return placed_list[$urandom_range(lo, placed_list.size() - 1)];
	endfunction

	function automatic node_t fresh_node();
		node_t n;
		do
			n = node_t'($urandom_range(1, MAX_NODES - 1));
		while (placed[n]);
		return n;
	endfunction

	// Walks a few steps up the current parent links. The step bound keeps this safe
	// once reinsertion has made the links circular.
	function automatic node_t lift_some(input node_t n);
		int steps;
		steps = $urandom_range(1, 12);
		while (steps > 0 && parent_of[n] != '0) begin
			n = parent_of[n];
			steps--;
		end
		return n;
	endfunction

	// One random word of the forest phase: mostly legal inserts and queries, with some
	// reinsertion (which leaves descendants' rows stale) and ignored inserts of node zero.
	task automatic forest_item();
		int    r;
		node_t a;
		node_t b;
		node_t t;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			send_word(OP_INSERT, '0, node_t'($urandom_range(0, MAX_NODES - 1)));
		end else if (r < 45 || placed_list.size() < 2) begin
			if (placed_list.size() < MAX_NODES - 1 && $urandom_range(0, 9) < 8)
				a = fresh_node();
			else
				a = any_placed();
			if (placed_list.size() == 0)
				b = '0;
			else begin
				case ($urandom_range(0, 9))
					0:       b = '0;
					1, 2, 3: b = any_placed();
					default: b = recent_placed();
				endcase
			end
			put_node(a, b);
		end else begin
			a = any_placed();
			case ($urandom_range(0, 9))
				0:       b = a;
				1:       b = '0;
				2: begin
					b = a;
					a = '0;
				end
				3, 4, 5: b = lift_some(a);
				default: b = any_placed();
			endcase
			if ($urandom_range(0, 1) == 1) begin
				t = a;
				a = b;
				b = t;
			end
			send_word(OP_QUERY, a, b);
		end
	endtask

	// Receiver: random short stalls, one long hold-off on request, none in the last part.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int    i;
		int    j;
		node_t a;
		node_t b;
		node_t t;

		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_INSERT;
		req_ch.first_node  <= '0;
		req_ch.second_node <= '0;
		arst_n             <= 1'b0;
		idle_en      = 1'b1;
		hold_req     = 1'b0;
		inserts_sent = 0;
		queries_sent = 0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Tree one: 1023 at the root, then 1, with 512 and 2 below 1, and
		// alternating bit patterns 341 and 682 as grandchildren. Tree two: 3 over 4.
		put_node(10'd1023, 10'd0);
		put_node(10'd1, 10'd1023);
		put_node(10'd512, 10'd1);
		put_node(10'd2, 10'd1);
		put_node(10'd341, 10'd512);
		put_node(10'd682, 10'd2);
		put_node(10'd3, 10'd0);
		put_node(10'd4, 10'd3);
		// Inserts of node zero must leave the tables alone.
		send_word(OP_INSERT, 10'd0, 10'd0);
		send_word(OP_INSERT, 10'd0, 10'd1023);
		// Cousins in both orders, then one node being an ancestor of the other.
		send_word(OP_QUERY, 10'd341, 10'd682);
		send_word(OP_QUERY, 10'd682, 10'd341);
		send_word(OP_QUERY, 10'd341, 10'd1023);
		send_word(OP_QUERY, 10'd1023, 10'd341);
		send_word(OP_QUERY, 10'd512, 10'd512);
		// Different trees give no ancestor, and so does any query naming node zero.
		send_word(OP_QUERY, 10'd341, 10'd4);
		send_word(OP_QUERY, 10'd0, 10'd341);
		send_word(OP_QUERY, 10'd341, 10'd0);
		send_word(OP_QUERY, 10'd0, 10'd0);
		// Move 512 under the second tree; 341 keeps its old, now stale, ancestor row.
		put_node(10'd512, 10'd3);
		send_word(OP_QUERY, 10'd341, 10'd4);
		send_word(OP_QUERY, 10'd512, 10'd4);
		send_word(OP_QUERY, 10'd1023, 10'd1023);

		// Random forest growth with queries; the long output stall lands in the middle.
		for (i = 0; i < FOREST_ITEMS; i++) begin
			if (i == FOREST_ITEMS / 2)
				hold_req = 1'b1;
			forest_item();
		end

		// Thread every nonzero node number into one path in random order. This drives the depth
		// to its ceiling and makes the lifting step use every bit of the depth gap.
		for (i = 0; i < MAX_NODES - 1; i++)
			path_order[i] = node_t'(i + 1);
		for (i = MAX_NODES - 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = path_order[i];
			path_order[i] = path_order[j];
			path_order[j] = t;
		end
		for (i = 0; i < MAX_NODES - 1; i++) begin
			if (i == QUIET_FROM)
				idle_en = 1'b0;
			if (i == 600)
				hold_req = 1'b1;
			put_node(path_order[i], (i == 0) ? node_t'(0) : path_order[i-1]);
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						a = path_order[i];
						b = path_order[$urandom_range(0, (i < 3) ? i : 3)];
					end
					1: begin
						a = path_order[$urandom_range(0, i)];
						b = any_placed();
					end
					default: begin
						a = path_order[$urandom_range(0, i)];
						b = path_order[$urandom_range(0, i)];
					end
				endcase
				send_word(OP_QUERY, a, b);
			end
		end
		// Hanging nodes below the deepest one makes the depth saturate.
		put_node(path_order[0], path_order[MAX_NODES-2]);
		put_node(path_order[1], path_order[0]);
		send_word(OP_QUERY, path_order[0], path_order[MAX_NODES-2]);
		send_word(OP_QUERY, path_order[1], path_order[500]);
		send_word(OP_QUERY, path_order[MAX_NODES-2], path_order[5]);
		send_word(OP_QUERY, path_order[1], path_order[0]);

		req_ch.valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d inserts and %0d queries; %0d answers compared.",
			inserts_sent, queries_sent, compared);
		$display({"It grew random forests, reinserted nodes, ",
			"and built a full-length path to depth saturation."});
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/lca_pkg.sv
rtl/lca_req_if.sv
rtl/lca_rsp_if.sv
rtl/lca_ram.sv
rtl/lca_engine.sv
rtl/binary_lifting_lca.sv
dv/lca_checker.sv
dv/binary_lifting_lca_tb.sv
